// ===== design/wclt_pkg.sv =====
// Shared types, constants and control structs of the channel level tracker.
package wclt_pkg;

  localparam int CHANNELS = 13;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef logic signed [23:0] sum_t;
  typedef logic        [15:0] count_t;
  typedef logic signed [15:0] level_t;

  localparam level_t LEVEL_FLOOR = -16'sd29440;
  localparam count_t COUNT_MAX   = 16'hFFFF;

  // serial divider: quotient is offset by 2**17 so the dividend is never negative
  localparam int DIV_STEPS = 18;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // dwell decay: floor(x / 5) as (x * ceil(2**22 / 5)) >> 22 with x = 4*L + 5*2**17,
  // exact for x < 2**22
  localparam logic [19:0] DWELL_OFS   = 20'd655360;
  localparam logic [19:0] DWELL_RECIP = 20'd838861;
  localparam int          DWELL_SHIFT = 22;

  localparam logic signed [17:0] DWELL_DROP = 18'sd5888;
  localparam logic signed [17:0] IDLE_DROP  = 18'sd128;

  // intensity: floor(t / 70) as (t * ceil(2**22 / 70)) >> 22, exact for t < 2**16
  localparam logic [15:0] INT_RECIP = 16'd59919;
  localparam int          INT_SHIFT = 22;

  typedef enum logic [1:0] {
    MODE_AVG,
    MODE_DWELL,
    MODE_HOLD
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic sample;
    logic start;
    logic stop;
    logic tick;
    logic load;
    logic prep;
    logic step;
    logic fin;
    logic emit;
    logic advance;
  } ctl_cmd_t;

  typedef struct packed {
    logic active;
    logic is_last;
    logic skip_div;
    logic div_done;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== design/wclt_if.sv =====
// Valid/ready channel interfaces for tracker commands and per-channel results.
interface wclt_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        channel;
  logic signed [7:0] rssi;
  logic [3:0]        dwell_channel;

  modport source (output valid, cmd, channel, rssi, dwell_channel, input ready);
  modport sink   (input valid, cmd, channel, rssi, dwell_channel, output ready);
endinterface

interface wclt_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic signed [15:0] level;
  logic [7:0]         intensity;
  logic               last;

  modport source (output valid, channel_index, level, intensity, last, input ready);
  modport sink   (input valid, channel_index, level, intensity, last, output ready);
endinterface

// ===== design/wclt_datapath.sv =====
// Tracker datapath: per-channel state, serial divider, level update and result register.
module wclt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  wclt_pkg::ctl_cmd_t   ctl,
  output wclt_pkg::ctl_sts_t   sts,
  input  logic [7:0]           channel,
  input  logic signed [7:0]    rssi,
  input  logic [3:0]           dwell_channel,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [3:0]           channel_index,
  output logic signed [15:0]   level,
  output logic [7:0]           intensity,
  output logic                 last
);
  import wclt_pkg::*;

  sum_t   channel_sum   [CHANNELS];
  count_t channel_count [CHANNELS];
  level_t channel_level [CHANNELS];
  logic   active;

  logic [IDX_W-1:0]  idx;
  logic [3:0]        dwell;
  mode_t             mode;
  level_t            cur_level;
  sum_t              cur_sum;
  count_t            cur_cnt;
  logic signed [32:0] prod;

  logic [15:0]       rem;
  logic [17:0]       quo;
  count_t            divisor;
  logic [STEP_W-1:0] step;
  logic [17:0]       dq;

  level_t            fin_level;
  logic [15:0]       scaled;

  logic              samp_ok;
  logic [IDX_W-1:0]  samp_idx;
  logic [7:0]        chan_num;
  logic              is_last;
  logic              dwell_hit;
  logic              out_free;

  logic [34:0]       num_avg;
  logic [16:0]       trial;
  logic [16:0]       diff;
  logic              ge;

  logic [19:0]       dwell_x;
  logic [39:0]       dwell_prod;

  logic signed [17:0] qs;
  logic signed [17:0] dqs;
  logic signed [17:0] nl;
  level_t             lv;
  logic [16:0]        lv_ofs;
  logic [23:0]        scaled_full;
  logic [31:0]        inten_prod;
  logic [9:0]         inten_raw;
  logic [7:0]         inten;

  assign samp_ok   = active && (channel >= 8'd1) && (channel <= 8'(CHANNELS));
  assign samp_idx  = IDX_W'(channel - 8'd1);
  assign chan_num  = 8'(idx) + 8'd1;
  assign is_last   = (idx == IDX_W'(CHANNELS - 1));
  assign dwell_hit = (chan_num == {4'd0, dwell});
  assign out_free  = !res_valid || res_ready;

  assign sts.active   = active;
  assign sts.is_last  = is_last;
  assign sts.skip_div = (mode != MODE_AVG);
  assign sts.div_done = (step == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free = out_free;

  // dividend = N + 2**17 * divisor, always in [0, 2**34)
  assign num_avg   = {{2{prod[32]}}, prod} + {{3{cur_sum[23]}}, cur_sum, 8'd0}
                   + {2'd0, cur_cnt, 17'd0};

  assign trial = {rem, quo[17]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  assign dwell_x    = {{2{cur_level[15]}}, cur_level, 2'd0} + DWELL_OFS;
  assign dwell_prod = dwell_x * DWELL_RECIP;

  assign qs  = $signed({~quo[17], quo[16:0]});
  assign dqs = $signed({~dq[17], dq[16:0]});

  always_comb begin
    case (mode)
      MODE_AVG:   nl = qs >>> 1;
      MODE_DWELL: nl = dqs - DWELL_DROP;
      MODE_HOLD:  nl = {{2{cur_level[15]}}, cur_level} - IDLE_DROP;
      default:    nl = {{2{cur_level[15]}}, cur_level};
    endcase
  end

  assign lv          = (nl < $signed({{2{LEVEL_FLOOR[15]}}, LEVEL_FLOOR})) ? LEVEL_FLOOR
                                                                           : nl[15:0];
  assign lv_ofs      = {lv[15], lv} - {LEVEL_FLOOR[15], LEVEL_FLOOR};
  assign scaled_full = {lv_ofs[15:0], 8'd0} - {8'd0, lv_ofs[15:0]};

  assign inten_prod = scaled * INT_RECIP;
  assign inten_raw  = inten_prod[31:INT_SHIFT];
  assign inten      = (inten_raw > 10'd255) ? 8'd255 : inten_raw[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_sum[i]   <= '0;
        channel_count[i] <= '0;
        channel_level[i] <= '0;
      end
    end else begin
      if (ctl.start) begin
        active <= 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          channel_sum[i]   <= '0;
          channel_count[i] <= '0;
          channel_level[i] <= '0;
        end
      end
      if (ctl.stop) begin
        active <= 1'b0;
      end
      if (ctl.sample && samp_ok && (channel_count[samp_idx] != COUNT_MAX)) begin
        channel_sum[samp_idx]   <= channel_sum[samp_idx] + {{16{rssi[7]}}, rssi};
        channel_count[samp_idx] <= channel_count[samp_idx] + 16'd1;
      end
      if (ctl.fin) begin
        channel_level[idx] <= lv;
        channel_sum[idx]   <= '0;
        channel_count[idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.tick) begin
      idx <= '0;
    end else if (ctl.advance) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      dwell <= dwell_channel;
    end
    if (ctl.load) begin
      cur_level <= channel_level[idx];
      cur_sum   <= channel_sum[idx];
      cur_cnt   <= channel_count[idx];
      prod      <= $signed(channel_level[idx]) * $signed({1'b0, channel_count[idx]});
      if (channel_count[idx] != '0) begin
        mode <= MODE_AVG;
      end else if (dwell_hit) begin
        mode <= MODE_DWELL;
      end else begin
        mode <= MODE_HOLD;
      end
    end
    if (ctl.prep) begin
      rem     <= num_avg[33:18];
      quo     <= num_avg[17:0];
      divisor <= cur_cnt;
      step    <= '0;
      dq      <= dwell_prod[DWELL_SHIFT+17:DWELL_SHIFT];
    end else if (ctl.step) begin
      rem  <= ge ? diff[15:0] : trial[15:0];
      quo  <= {quo[16:0], ge};
      step <= step + STEP_W'(1);
    end
    if (ctl.fin) begin
      fin_level <= lv;
      scaled    <= scaled_full[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      channel_index <= chan_num[3:0];
      level         <= fin_level;
      intensity     <= inten;
      last          <= is_last;
    end
  end

endmodule

// ===== design/wclt_ctrl.sv =====
// Tracker controller: command decode and the per-channel frame walk sequence.
module wclt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  wclt_pkg::cmd_t     op,
  input  wclt_pkg::ctl_sts_t sts,
  output wclt_pkg::ctl_cmd_t ctl
);
  import wclt_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;

  assign take = item_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (op == CMD_TICK) && sts.active) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_PREP;
      ST_PREP: state_next = sts.skip_div ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.is_last ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        ctl.sample = take && (op == CMD_SAMPLE);
        ctl.tick   = take && (op == CMD_TICK) && sts.active;
        ctl.start  = take && (op == CMD_START);
        ctl.stop   = take && (op == CMD_STOP);
      end
      ST_LOAD: ctl.load = 1'b1;
      ST_PREP: ctl.prep = 1'b1;
      ST_DIV:  ctl.step = 1'b1;
      ST_FIN:  ctl.fin  = 1'b1;
      ST_EMIT: begin
        ctl.emit    = sts.out_free;
        ctl.advance = sts.out_free && !sts.is_last;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== design/wifi_channel_level_tracker.sv =====
// Top level of the per-channel signal level tracker.
// Use: one command channel (item) and one result channel (result), both valid/ready.
// cmd sample adds rssi to the sum and count of channels 1..13 while enabled.
// start clears all sums, counts and levels and enables; stop disables; each gives
// no result. A frame tick while enabled walks channels 1..13 and gives one result
// transaction each, last set on channel 13. A channel without samples takes the
// 0.5 dB drop, or the dwell decay by reciprocal multiply; for a channel with samples
// the 18-step restoring divider runs. item.ready stays low until the walk has handed
// its last result to the output register.
// The output register holds a result until the receiver takes it; a stalled result
// stalls the walk, and once the walk is done new commands are accepted while the
// last result still waits.
// Reset (rst, synchronous) clears all channel state, disables tracking and drops any
// pending result.
module wifi_channel_level_tracker (
  input logic           clk,
  input logic           rst,
  wclt_item_if.sink     item,
  wclt_result_if.source result
);
  import wclt_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  wclt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .op         (cmd_t'(item.cmd)),
    .sts        (sts),
    .ctl        (ctl)
  );

  wclt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .channel       (item.channel),
    .rssi          (item.rssi),
    .dwell_channel (item.dwell_channel),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .channel_index (result.channel_index),
    .level         (result.level),
    .intensity     (result.intensity),
    .last          (result.last)
  );

endmodule

// ===== design/wclt_checker.sv =====
// Port-level checks of the tracker, bound to the top level.
module wclt_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [3:0]         channel_index,
  input logic signed [15:0] level,
  input logic [7:0]         intensity,
  input logic               last
);
  import wclt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(level) && $stable(channel_index))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (channel_index >= 4'd1) && (channel_index <= 4'(CHANNELS)))
    else $error("channel index out of range");

  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (channel_index == 4'(CHANNELS))))
    else $error("last flag does not match final channel");

  a_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (level >= LEVEL_FLOOR) && ((level != LEVEL_FLOOR) || (intensity == 8'd0)))
    else $error("level below floor or intensity wrong at floor");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind wifi_channel_level_tracker wclt_checker u_wclt_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .channel_index (result.channel_index),
  .level         (result.level),
  .intensity     (result.intensity),
  .last          (result.last)
);

// ===== sim/wifi_channel_level_tracker_tb.sv =====
// Self-checking testbench for the channel level tracker: predicted frame reports vs DUT output.
module wifi_channel_level_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wclt_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_ITEMS  = 370;

  typedef struct packed {
    logic [3:0] idx;
    level_t     level;
    logic [7:0] inten;
    logic       last;
  } chan_report_t;

  class level_scoreboard;
    int           sum_acc [CHANNELS];
    int unsigned  cnt_acc [CHANNELS];
    level_t       lvl [CHANNELS];
    bit           tracking;
    chan_report_t reports_due [$];
    int           mismatches;

    function new();
      clear_channels();
      tracking   = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_channels();
      foreach (lvl[i]) begin
        sum_acc[i] = 0;
        cnt_acc[i] = 0;
        lvl[i]     = '0;
      end
    endfunction

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function void note_item(cmd_t c, logic [7:0] ch, logic signed [7:0] rs, logic [3:0] dw);
      longint       lv;
      longint       inten;
      chan_report_t r;
      case (c)
        CMD_SAMPLE: begin
          if (tracking && ch >= 1 && ch <= CHANNELS && cnt_acc[ch-1] < COUNT_MAX) begin
            sum_acc[ch-1] += int'(rs);
            cnt_acc[ch-1]++;
          end
        end
        CMD_TICK: begin
          if (tracking) begin
            for (int k = 1; k <= CHANNELS; k++) begin
              lv = lvl[k-1];
              if (cnt_acc[k-1] != 0)
                lv = floor_quot(lv * longint'(cnt_acc[k-1]) + longint'(sum_acc[k-1]) * 256,
                                2 * longint'(cnt_acc[k-1]));
              else if (int'(dw) == k)
                lv = floor_quot(lv * 4, 5) - 23 * 256;
              else
                lv = lv - 128;
              if (lv < LEVEL_FLOOR) lv = LEVEL_FLOOR;
              lvl[k-1]     = level_t'(lv);
              sum_acc[k-1] = 0;
              cnt_acc[k-1] = 0;
              inten = ((lv - LEVEL_FLOOR) * 255) / (70 * 256);
              if (inten > 255) inten = 255;
              if (inten < 0) inten = 0;
              r.idx   = 4'(k);
              r.level = level_t'(lv);
              r.inten = 8'(inten);
              r.last  = (k == CHANNELS);
              reports_due.push_back(r);
            end
          end
        end
        CMD_START: begin
          clear_channels();
          tracking = 1'b1;
        end
        CMD_STOP: tracking = 1'b0;
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [3:0] idx, level_t level, logic [7:0] inten, logic last);
      chan_report_t got;
      chan_report_t want;
      got = '{idx: idx, level: level, inten: inten, last: last};
      if (reports_due.size() == 0) begin
        flag($sformatf("unexpected result: ch %0d level %0d intensity %0d last %0b",
                       idx, level, inten, last));
      end else begin
        want = reports_due.pop_front();
        if (got != want)
          flag($sformatf({"result mismatch: exp ch %0d level %0d int %0d last %0b, ",
                          "got ch %0d level %0d int %0d last %0b"},
                         want.idx, want.level, want.inten, want.last,
                         idx, level, inten, last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  wclt_item_if   item_bus ();
  wclt_result_if result_bus ();

  wifi_channel_level_tracker dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  level_scoreboard tracker_sb = new();

  int burst_left = 0;
  int sent_items = 0;
  int idle_cycles;

  always #5 clk = ~clk;

  task automatic drive_cmd(cmd_t c, logic [7:0] ch, logic signed [7:0] rs, logic [3:0] dw);
    if (burst_left == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    item_bus.valid         <= 1'b1;
    item_bus.cmd           <= c;
    item_bus.channel       <= ch;
    item_bus.rssi          <= rs;
    item_bus.dwell_channel <= dw;
    do @(posedge clk); while (!item_bus.ready);
    tracker_sb.note_item(c, ch, rs, dw);
    sent_items++;
  endtask

  task automatic drive_sample(logic [7:0] ch, logic signed [7:0] rs);
    drive_cmd(CMD_SAMPLE, ch, rs, 4'($urandom_range(0, 15)));
  endtask

  task automatic drive_tick(logic [3:0] dw);
    drive_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), dw);
  endtask

  task automatic drive_ctl(cmd_t c);
    drive_cmd(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              4'($urandom_range(0, 15)));
  endtask

  // receiver: ready steps through a random bit mask that is re-drawn whenever the phase counter wraps
  initial begin
    logic [7:0] mask;
    logic [5:0] phase;
    result_bus.ready <= 1'b0;
    mask  = 8'hFF;
    phase = '0;
    forever begin
      @(posedge clk);
      if (phase == 6'd63) begin
        case ($urandom_range(0, 3))
          0: mask = 8'hFF;
          1: mask = 8'($urandom_range(1, 255));
          2: mask = 8'h01;
          default: mask = 8'hF0;
        endcase
      end
      result_bus.ready <= mask[phase[2:0]];
      phase++;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      tracker_sb.check_result(result_bus.channel_index, result_bus.level,
                              result_bus.intensity, result_bus.last);
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          n;
    int          rv;
    logic [7:0]  ch;
    item_bus.valid         <= 1'b0;
    item_bus.cmd           <= CMD_SAMPLE;
    item_bus.channel       <= '0;
    item_bus.rssi          <= '0;
    item_bus.dwell_channel <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // inactive after reset: all ignored
    drive_sample(8'd1, -8'sd50);
    drive_tick(4'd1);
    drive_ctl(CMD_START);
    drive_sample(8'd1, -8'sd128);
    drive_sample(8'd13, 8'sd127);
    drive_sample(8'd0, 8'sd10);
    drive_sample(8'd14, 8'sd10);
    drive_sample(8'd255, -8'sd1);
    drive_sample(8'd2, -8'sd1);
    drive_sample(8'd2, -8'sd2);
    drive_tick(4'd3);
    drive_tick(4'd0);
    drive_tick(4'd15);
    drive_tick(4'd14);
    drive_ctl(CMD_STOP);
    drive_sample(8'd1, 8'sd127);
    drive_tick(4'd1);
    drive_ctl(CMD_START);
    repeat (3) drive_sample(8'd5, 8'sd127);
    drive_tick(4'd5);
    repeat (8) drive_tick(4'd4);
    drive_tick(4'd13);

    while (sent_items < NUM_ITEMS) begin
      if ($urandom_range(0, 99) < 4) begin
        drive_ctl(CMD_STOP);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) == 0)
            drive_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          else
            drive_tick(4'($urandom_range(0, 15)));
        end
        drive_ctl(CMD_START);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0)
            ch = 8'($urandom_range(0, 255));
          else
            ch = 8'($urandom_range(1, CHANNELS));
          if ($urandom_range(0, 9) < 7)
            rv = int'($urandom_range(0, 80)) - 100;
          else
            rv = int'($urandom_range(0, 255));
          drive_sample(ch, 8'(rv));
        end
        drive_tick(4'($urandom_range(0, 15)));
      end
    end

    item_bus.valid <= 1'b0;
    while (tracker_sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker_sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
